@@ rtl/jrv_pkg.sv @@
// ============================================================================
// Journal record validator package
// Shared types, constants and the CRC-32 byte step for the record validator.
// ============================================================================
`default_nettype none

package jrv_pkg;

  // Position counter width and its saturation value.
  localparam int unsigned PosW = 20;
  localparam logic [PosW-1:0] PosMax = '1;

  // Fixed header layout.
  localparam int unsigned HeaderBytes = 24;
  localparam int unsigned OffsetW = 5;

  // Default payload limit for the top-level parameter.
  localparam int unsigned MaxPayloadDef = 65536;

  // Configuration register widths and reset values.
  localparam int unsigned MaxCfgW = 17;
  localparam logic [31:0] SchemaVersionReset = 32'd1;
  localparam logic [MaxCfgW-1:0] MaxPayloadReset = 17'h10000;

  // Register map: the register index is byte address bit 2.
  localparam int unsigned AddrW = 3;
  localparam logic RegSchemaVersion = 1'b0;
  localparam logic RegMaxPayload = 1'b1;

  // Reflected CRC-32 polynomial.
  localparam logic [31:0] CrcPoly = 32'hedb88320;

  // Eight-byte magic; the first four bytes are the reserved prefix.
  localparam logic [7:0] Magic [8] = '{8'h56, 8'h4f, 8'h56, 8'h45,
                                       8'h43, 8'h55, 8'h52, 8'h52};

  // Verdict codes.
  typedef enum logic [1:0] {
    StTyped   = 2'd0,
    StLegacy  = 2'd1,
    StCorrupt = 2'd2
  } status_e;

  // Configuration register contents.
  typedef struct packed {
    logic [31:0]        schema_version;
    logic [MaxCfgW-1:0] max_payload_bytes;
  } cfg_t;

  // One verdict.
  typedef struct packed {
    status_e             status;
    logic [31:0]         kind;
    logic [OffsetW-1:0]  payload_offset;
    logic [PosW-1:0]     payload_length;
    logic                length_saturated;
  } result_t;

  // One byte of a reflected CRC-32, bit by bit.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0] data);
    logic [31:0] crc;
    crc = crc_in ^ {24'h000000, data};
    for (int i = 0; i < 8; i++) begin
      crc = (crc >> 1) ^ (crc[0] ? CrcPoly : 32'h0);
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

@@ rtl/jrv_if.sv @@
// ============================================================================
// Journal record validator channels
// Valid/ready channels for record bytes in and verdicts out.
// ============================================================================
`default_nettype none

// Record byte channel.
interface jrv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;
  logic       empty_record;

  modport source(output valid, output data_byte, output last, output empty_record,
                 input ready);
  modport sink(input valid, input data_byte, input last, input empty_record,
               output ready);
endinterface

// Verdict channel.
interface jrv_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] kind;
  logic [4:0]  payload_offset;
  logic [19:0] payload_length;
  logic        length_saturated;

  modport source(output valid, output status, output kind, output payload_offset,
                 output payload_length, output length_saturated, input ready);
  modport sink(input valid, input status, input kind, input payload_offset,
               input payload_length, input length_saturated, output ready);
endinterface

`default_nettype wire

@@ rtl/jrv_cfg_regs.sv @@
// ============================================================================
// Journal record validator configuration registers
// APB-style register file holding the schema version and payload limit.
// ============================================================================
`default_nettype none

module jrv_cfg_regs (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [jrv_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready,
  output jrv_pkg::cfg_t                  cfg_o
);
  import jrv_pkg::*;

  cfg_t cfg_q;
  logic wr_en;
  logic reg_sel;

  // The port never stalls.
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.schema_version    <= SchemaVersionReset;
      cfg_q.max_payload_bytes <= MaxPayloadReset;
    end else if (wr_en) begin
      unique case (reg_sel)
        RegSchemaVersion: cfg_q.schema_version    <= pwdata;
        RegMaxPayload:    cfg_q.max_payload_bytes <= pwdata[MaxCfgW-1:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (reg_sel)
      RegSchemaVersion: prdata = cfg_q.schema_version;
      RegMaxPayload:    prdata = {{(32-MaxCfgW){1'b0}}, cfg_q.max_payload_bytes};
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/jrv_core.sv @@
// ============================================================================
// Journal record validator core
// Per-record state, header capture, payload CRC and the end-of-record verdict.
// ============================================================================
`default_nettype none

module jrv_core #(
  parameter int unsigned MAX_PAYLOAD = jrv_pkg::MaxPayloadDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            take_i,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic            last_i,
  input  wire logic            empty_record_i,
  input  wire jrv_pkg::cfg_t   cfg_i,
  output logic                 finish_o,
  output jrv_pkg::result_t     result_o
);
  import jrv_pkg::*;

  localparam logic [31:0] MaxPayloadW = 32'(MAX_PAYLOAD);

  typedef struct packed {
    logic [PosW-1:0] pos;
    logic            prefix_ok;
    logic            magic_ok;
    logic [31:0]     version;
    logic [31:0]     kind;
    logic [31:0]     length;
    logic [31:0]     hdr_crc;
    logic [31:0]     crc;
    logic            ovf;
  } rec_state_t;

  localparam rec_state_t RecClear = '{
    pos: '0, prefix_ok: 1'b1, magic_ok: 1'b1, version: '0, kind: '0,
    length: '0, hdr_crc: '0, crc: '1, ovf: 1'b0
  };

  rec_state_t st_q, st_d;
  rec_state_t taken;
  rec_state_t fin_st;
  logic [PosW-1:0] p;
  logic [4:0]      lane;
  logic [31:0]     limit;
  logic            has_prefix;
  logic            has_magic;
  logic            typed_ok;

  assign finish_o = empty_record_i || last_i;
  assign limit = (MaxPayloadW < {15'd0, cfg_i.max_payload_bytes})
               ? MaxPayloadW : {15'd0, cfg_i.max_payload_bytes};

  // State after taking the incoming byte.
  always_comb begin
    taken = st_q;
    p     = st_q.pos;
    lane  = {p[1:0], 3'b000};
    if (p < PosW'(8)) begin
      if (data_byte_i != Magic[p[2:0]]) begin
        taken.magic_ok = 1'b0;
        if (p < PosW'(4)) begin
          taken.prefix_ok = 1'b0;
        end
      end
    end else if (p < PosW'(12)) begin
      taken.version[lane +: 8] = data_byte_i;
    end else if (p < PosW'(16)) begin
      taken.kind[lane +: 8] = data_byte_i;
    end else if (p < PosW'(20)) begin
      taken.length[lane +: 8] = data_byte_i;
    end else if (p < PosW'(HeaderBytes)) begin
      taken.hdr_crc[lane +: 8] = data_byte_i;
    end else begin
      taken.crc = crc_byte(st_q.crc, data_byte_i);
    end
    if (p == PosMax) begin
      taken.ovf = 1'b1;
    end else begin
      taken.pos = p + PosW'(1);
    end
  end

  // Verdict from the state at the end of the record.
  always_comb begin
    fin_st     = empty_record_i ? st_q : taken;
    has_prefix = (fin_st.pos >= PosW'(4)) && fin_st.prefix_ok;
    has_magic  = (fin_st.pos >= PosW'(8)) && fin_st.magic_ok;
    typed_ok   = (fin_st.pos >= PosW'(HeaderBytes))
              && (fin_st.version == cfg_i.schema_version)
              && (fin_st.kind != 32'd0)
              && (fin_st.length <= limit)
              && !fin_st.ovf
              && ({13'd0, fin_st.pos} == (33'(HeaderBytes) + {1'b0, fin_st.length}))
              && ((fin_st.crc ^ 32'hffffffff) == fin_st.hdr_crc);

    result_o.status           = StCorrupt;
    result_o.kind             = '0;
    result_o.payload_offset   = '0;
    result_o.payload_length   = '0;
    result_o.length_saturated = fin_st.ovf;
    if (!has_magic) begin
      if (!has_prefix) begin
        result_o.status         = StLegacy;
        result_o.payload_length = fin_st.pos;
      end
    end else if (typed_ok) begin
      result_o.status         = StTyped;
      result_o.kind           = fin_st.kind;
      result_o.payload_offset = OffsetW'(HeaderBytes);
      result_o.payload_length = fin_st.length[PosW-1:0];
    end
  end

  // Next record state: cleared after each verdict.
  always_comb begin
    st_d = st_q;
    if (take_i) begin
      st_d = finish_o ? RecClear : taken;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= RecClear;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/journal_record_validator_unit.sv @@
// ============================================================================
// Journal record validator unit
// Byte-stream record checker giving one verdict per stored record.
// ============================================================================
// Record bytes enter one per request on the input channel, with a last mark or
// an empty-record mark, and each record yields one verdict request: typed
// valid, legacy untyped or corrupt. The unit takes one byte per cycle unless a
// byte that ends a record waits on a full verdict slot; a byte is held in the
// input register and, when it ends a record, its verdict is loaded into the
// output register as that byte is taken. The per-byte CRC step and header
// capture are one pass of logic between those registers. A waiting verdict
// holds only bytes that end a record; other bytes keep flowing. Write the
// registers only while idle.
`default_nettype none

module journal_record_validator_unit #(
  parameter int unsigned MAX_PAYLOAD = jrv_pkg::MaxPayloadDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [jrv_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready,
  jrv_in_if.sink                         in_if,
  jrv_out_if.source                      out_if
);
  import jrv_pkg::*;

  cfg_t       cfg;
  result_t    core_res;
  result_t    res_q;
  logic       core_fin;
  logic       core_take;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       in_empty_q;
  logic       out_valid_q;

  jrv_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // The held byte moves on unless it ends a record and the verdict slot is full.
  assign core_take = in_valid_q && (!core_fin || !out_valid_q || out_if.ready);
  assign in_if.ready = !in_valid_q || core_take;

  jrv_core #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (core_take),
    .data_byte_i   (in_byte_q),
    .last_i        (in_last_q),
    .empty_record_i(in_empty_q),
    .cfg_i         (cfg),
    .finish_o      (core_fin),
    .result_o      (core_res)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      in_byte_q  <= in_if.data_byte;
      in_last_q  <= in_if.last;
      in_empty_q <= in_if.empty_record;
    end
  end

  // Verdict register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_take && core_fin) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_take && core_fin) begin
      res_q <= core_res;
    end
  end

  assign out_if.valid            = out_valid_q;
  assign out_if.status           = res_q.status;
  assign out_if.kind             = res_q.kind;
  assign out_if.payload_offset   = res_q.payload_offset;
  assign out_if.payload_length   = res_q.payload_length;
  assign out_if.length_saturated = res_q.length_saturated;

endmodule

`default_nettype wire

@@ tb/tb_journal_record_validator_unit.sv @@
// ============================================================================
// Journal record validator unit testbench
// Streams directed and random stored records through the validator under
// random idling on both channels, predicts each verdict not given by the script
// from a byte-level record scanner and checks each verdict field in order.
// ============================================================================
`timescale 1ns / 1ps

module tb_journal_record_validator_unit;
  import jrv_pkg::*;

  localparam int unsigned MaxPayload = MaxPayloadDef;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned PressureHold = 400;
  localparam int unsigned PhaseItems = 200;

  // Ways a well-formed typed record gets damaged in the random part.
  typedef enum int unsigned {
    MutVersion, MutKind, MutLength, MutCrc, MutPayload,
    MutMagic, MutPrefix, MutTruncate, MutExtra, MutOverLimit
  } flaw_e;

  // Shapes of random records.
  typedef enum int unsigned {
    ShapeTyped, ShapeLegacy, ShapePrefixOnly, ShapeMagicOnly, ShapePartialPrefix
  } rec_shape_e;

  // Scanner state for the record being received.
  typedef struct {
    logic [PosW-1:0] position;
    bit              prefix_ok;
    bit              magic_ok;
    logic [31:0]     version;
    logic [31:0]     kind;
    logic [31:0]     length;
    logic [31:0]     crc_field;
    logic [31:0]     crc_run;
    bit              overflow;
  } record_scan_t;

  // One line of the directed script; copies repeats the byte.
  typedef struct {
    logic [7:0]  data_byte;
    bit          last;
    bit          empty_mark;
    int unsigned copies;
    bit          verdict_given;
    result_t     verdict;
  } script_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrW-1:0]    paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  jrv_in_if  byte_ch ();
  jrv_out_if verdict_ch ();

  // Predictor state and register copies.
  record_scan_t        scan;
  logic [31:0]         cfg_schema;
  logic [MaxCfgW-1:0]  cfg_max_payload;

  result_t             verdicts_due [$];
  logic [7:0]          record_bytes [$];
  script_row_t         directed_rows [$];

  int unsigned error_count = 0;
  int unsigned verdicts_checked = 0;
  int unsigned typed_seen = 0;
  int unsigned legacy_seen = 0;
  int unsigned corrupt_seen = 0;
  int unsigned items_sent = 0;
  int unsigned settings_used = 0;
  int unsigned burst_left = 0;
  bit          hold_req = 1'b0;

  journal_record_validator_unit #(
    .MAX_PAYLOAD(MaxPayload)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .in_if  (byte_ch),
    .out_if (verdict_ch)
  );

  always #5 clk_i = ~clk_i;

  // Serial reflected CRC-32, one data bit per step.
  function automatic logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ b[i]) c = (c >> 1) ^ CrcPoly;
      else c = c >> 1;
    end
    return c;
  endfunction

  function automatic void clear_scan();
    scan.position  = '0;
    scan.prefix_ok = 1'b1;
    scan.magic_ok  = 1'b1;
    scan.version   = '0;
    scan.kind      = '0;
    scan.length    = '0;
    scan.crc_field = '0;
    scan.crc_run   = '1;
    scan.overflow  = 1'b0;
  endfunction

  // Magic compare, header capture by 4-byte lane, payload CRC, count.
  function automatic void absorb_byte(logic [7:0] b);
    logic [PosW-1:0] p;
    int unsigned     lane;
    p = scan.position;
    lane = 8 * int'(p[1:0]);
    if (p < 8) begin
      if (b != Magic[p[2:0]]) begin
        scan.magic_ok = 1'b0;
        if (p < 4) scan.prefix_ok = 1'b0;
      end
    end else if (p < 12) begin
      scan.version[lane +: 8] = b;
    end else if (p < 16) begin
      scan.kind[lane +: 8] = b;
    end else if (p < 20) begin
      scan.length[lane +: 8] = b;
    end else if (p < HeaderBytes) begin
      scan.crc_field[lane +: 8] = b;
    end else begin
      scan.crc_run = crc_step(scan.crc_run, b);
    end
    if (p == PosMax) scan.overflow = 1'b1;
    else scan.position = p + 1'b1;
  endfunction

  // Verdict for the bytes gathered so far; the scanner starts over.
  function automatic result_t close_record();
    result_t         v;
    logic [PosW-1:0] n;
    logic [31:0]     limit;
    bit              has_prefix;
    bit              has_magic;
    n = scan.position;
    has_prefix = (n >= 4) && scan.prefix_ok;
    has_magic = (n >= 8) && scan.magic_ok;
    limit = (cfg_max_payload > MaxPayload) ? 32'(MaxPayload) : 32'(cfg_max_payload);
    v = '0;
    v.status = StCorrupt;
    if (!has_magic) begin
      if (!has_prefix) begin
        v.status = StLegacy;
        v.payload_length = n;
      end
    end else if (n >= HeaderBytes && scan.version == cfg_schema && scan.kind != 0 &&
                 scan.length <= limit && !scan.overflow &&
                 64'(n) == 64'(HeaderBytes) + 64'(scan.length) &&
                 ~scan.crc_run == scan.crc_field) begin
      v.status = StTyped;
      v.kind = scan.kind;
      v.payload_offset = OffsetW'(HeaderBytes);
      v.payload_length = scan.length[PosW-1:0];
    end
    v.length_saturated = scan.overflow;
    clear_scan();
    return v;
  endfunction

  // Returns 1 when the request ends a record, with its verdict.
  function automatic bit predict_item(logic [7:0] b, bit last, bit mark, output result_t v);
    v = '0;
    if (mark) begin
      v = close_record();
      return 1'b1;
    end
    absorb_byte(b);
    if (last) begin
      v = close_record();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_t verdict_of(status_e s, logic [PosW-1:0] len, bit sat);
    result_t v;
    v = '0;
    v.status = s;
    v.payload_length = len;
    v.length_saturated = sat;
    return v;
  endfunction

  function automatic void add_row(logic [7:0] b, bit last, bit mark, int unsigned copies,
                                  bit given, result_t verdict);
    script_row_t row;
    row.data_byte = b;
    row.last = last;
    row.empty_mark = mark;
    row.copies = copies;
    row.verdict_given = given;
    row.verdict = verdict;
    directed_rows.push_back(row);
  endfunction

  // Sender gap: mostly none or short, a few long, with gap-free bursts.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      burst_left = $urandom_range(40, 200);
      return 0;
    end
    if (r < 6) return $urandom_range(8, 40);
    if (r < 30) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Offer one request, wait for it to be taken, record its verdict if any.
  task automatic send_item(logic [7:0] b, bit last, bit mark, bit given, result_t given_verdict,
                           bit steady);
    result_t     v;
    int unsigned gap;
    byte_ch.valid <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last <= last;
    byte_ch.empty_record <= mark;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
    if (predict_item(b, last, mark, v)) verdicts_due.push_back(given ? given_verdict : v);
    items_sent++;
    if (!steady) begin
      gap = pick_gap();
      if (gap > 0) begin
        byte_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Send the gathered record, ended by a last byte or by an empty mark.
  task automatic send_record(bit end_mark);
    int unsigned n;
    result_t     unused;
    n = record_bytes.size();
    unused = '0;
    for (int unsigned i = 0; i < n; i++) begin
      send_item(record_bytes[i], !end_mark && (i == n - 1), 1'b0, 1'b0, unused, 1'b0);
    end
    if (end_mark) send_item(8'($urandom()), 1'($urandom()), 1'b1, 1'b0, unused, 1'b0);
  endtask

  function automatic void put_word(logic [31:0] w);
    for (int i = 0; i < 4; i++) record_bytes.push_back(w[8*i +: 8]);
  endfunction

  // Typed record with a correct header and CRC, sometimes damaged in one place.
  function automatic void build_typed();
    logic [31:0] limit;
    logic [31:0] version;
    logic [31:0] kind;
    logic [31:0] hlen;
    logic [31:0] crc;
    logic [7:0]  payload [$];
    int unsigned len;
    int unsigned spot;
    bit          flawed;
    flaw_e       flaw;
    limit = (cfg_max_payload > MaxPayload) ? 32'(MaxPayload) : 32'(cfg_max_payload);
    len = (limit == 0) ? 0 : $urandom_range(0, (limit < 20) ? limit : 20);
    if ($urandom_range(0, 9) == 0) len = (limit < 40) ? limit : 40;
    flawed = ($urandom_range(0, 99) < 35);
    flaw = flaw_e'($urandom_range(0, int'(MutOverLimit)));
    if (flawed && flaw == MutOverLimit && limit < 40) len = limit + 1;
    crc = '1;
    for (int unsigned i = 0; i < len; i++) begin
      payload.push_back(8'($urandom()));
      crc = crc_step(crc, payload[i]);
    end
    crc = ~crc;
    version = cfg_schema;
    hlen = len;
    case ($urandom_range(0, 3))
      0: kind = '1;
      1: kind = 32'd1;
      default: kind = $urandom();
    endcase
    if (kind == 0) kind = 32'd1;

    // Header damage goes in before the bytes are laid out.
    if (flawed) begin
      case (flaw)
        MutVersion: version ^= 32'h1 << $urandom_range(0, 31);
        MutKind: kind = '0;
        MutLength: hlen = $urandom_range(0, 1) ? hlen + 1 : $urandom();
        MutCrc: crc ^= 32'h1 << $urandom_range(0, 31);
        MutOverLimit: if (limit >= 40) hlen = limit + 1;
        default: ;
      endcase
    end
    record_bytes.delete();
    for (int i = 0; i < 8; i++) record_bytes.push_back(Magic[i]);
    put_word(version);
    put_word(kind);
    put_word(hlen);
    put_word(crc);
    foreach (payload[i]) record_bytes.push_back(payload[i]);

    // Byte-level damage on the finished record.
    if (flawed) begin
      case (flaw)
        MutPayload: begin
          spot = (len > 0) ? $urandom_range(HeaderBytes, HeaderBytes + len - 1)
                           : $urandom_range(20, 23);
          record_bytes[spot] ^= 8'($urandom_range(1, 255));
        end
        MutMagic: record_bytes[$urandom_range(4, 7)] ^= 8'($urandom_range(1, 255));
        MutPrefix: record_bytes[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
        MutTruncate: begin
          repeat ($urandom_range(1, record_bytes.size())) void'(record_bytes.pop_back());
        end
        MutExtra: record_bytes.push_back(8'($urandom()));
        default: ;
      endcase
    end
  endfunction

  // Untyped shapes: plain bytes, or part of the magic followed by noise.
  function automatic void build_plain(rec_shape_e shape);
    int unsigned head;
    int unsigned tail;
    record_bytes.delete();
    case (shape)
      ShapePrefixOnly: begin
        head = 4;
        tail = $urandom_range(0, 3);
      end
      ShapeMagicOnly: begin
        head = 8;
        tail = $urandom_range(0, 15);
      end
      ShapePartialPrefix: begin
        head = $urandom_range(1, 3);
        tail = $urandom_range(0, 10);
      end
      default: begin
        head = 0;
        tail = $urandom_range(0, 30);
      end
    endcase
    for (int unsigned i = 0; i < head; i++) record_bytes.push_back(Magic[i]);
    repeat (tail) record_bytes.push_back(8'($urandom()));
  endfunction

  // Whole random records until the phase has sent enough requests.
  task automatic run_random_phase(int unsigned target);
    int unsigned start;
    int unsigned r;
    rec_shape_e  shape;
    bit          mark;
    start = items_sent;
    while (items_sent - start < target) begin
      r = $urandom_range(0, 99);
      if (r < 55) shape = ShapeTyped;
      else if (r < 70) shape = ShapeLegacy;
      else if (r < 80) shape = ShapePrefixOnly;
      else if (r < 90) shape = ShapeMagicOnly;
      else shape = ShapePartialPrefix;
      if (shape == ShapeTyped) build_typed();
      else build_plain(shape);
      mark = (record_bytes.size() == 0) || ($urandom_range(0, 6) == 0);
      send_record(mark);
    end
    byte_ch.valid <= 1'b0;
  endtask

  // Wait for every outstanding verdict, then let the pipeline settle.
  task automatic drain_and_settle();
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register write: setup, then access.
  task automatic reg_write(logic reg_sel, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_sel == RegSchemaVersion) cfg_schema = value;
    else cfg_max_payload = value[MaxCfgW-1:0];
  endtask

  task automatic apply_setting(logic [31:0] schema, logic [MaxCfgW-1:0] limit);
    reg_write(RegSchemaVersion, schema);
    reg_write(RegMaxPayload, 32'(limit));
    settings_used++;
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: verdict %0d %s expected 0x%0h actual 0x%0h", $time,
               verdicts_checked, name, want, got);
    end
  endfunction

  // Compare one delivered verdict with the oldest one predicted.
  function automatic void check_verdict();
    result_t want;
    if (verdicts_due.size() == 0) begin
      error_count++;
      $display("%0t: verdict expected none actual status 0x%0h length 0x%0h", $time,
               verdict_ch.status, verdict_ch.payload_length);
      return;
    end
    want = verdicts_due.pop_front();
    verdicts_checked++;
    case (want.status)
      StTyped: typed_seen++;
      StLegacy: legacy_seen++;
      default: corrupt_seen++;
    endcase
    check_field("status", want.status, verdict_ch.status);
    check_field("kind", want.kind, verdict_ch.kind);
    check_field("payload_offset", want.payload_offset, verdict_ch.payload_offset);
    check_field("payload_length", want.payload_length, verdict_ch.payload_length);
    check_field("length_saturated", want.length_saturated, verdict_ch.length_saturated);
  endfunction

  // Verdict receiver: random stalls, calm stretches and one long hold-off.
  initial begin
    int unsigned stall_left;
    int unsigned calm_left;
    int unsigned r;
    stall_left = 0;
    calm_left = 0;
    verdict_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (verdict_ch.valid && verdict_ch.ready) check_verdict();
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = PressureHold;
        calm_left = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        verdict_ch.ready <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        verdict_ch.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          calm_left = $urandom_range(30, 150);
          verdict_ch.ready <= 1'b1;
        end else if (r < 6) begin
          stall_left = $urandom_range(8, 40);
          verdict_ch.ready <= 1'b0;
        end else if (r < 30) begin
          stall_left = $urandom_range(0, 2);
          verdict_ch.ready <= 1'b0;
        end else begin
          verdict_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: ends the run when no request moves on either channel for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((byte_ch.valid && byte_ch.ready) || (verdict_ch.valid && verdict_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: watchdog, %0d cycles without a request moving", $time, quiet);
    $display("tb_journal_record_validator_unit: errors");
    $finish;
  end

  // Main sequence: reset, directed script, then random phases per setting.
  initial begin
    script_row_t        row;
    logic [31:0]        schema;
    logic [MaxCfgW-1:0] limit;
    bit                 final_copy;
    rst_ni <= 1'b0;
    byte_ch.valid <= 1'b0;
    byte_ch.data_byte <= '0;
    byte_ch.last <= 1'b0;
    byte_ch.empty_record <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cfg_schema = SchemaVersionReset;
    cfg_max_payload = MaxPayloadReset;
    clear_scan();

    // Empty record alone, then single bytes at both extremes.
    add_row(8'h00, 1'b0, 1'b1, 1, 1'b1, verdict_of(StLegacy, 20'd0, 1'b0));
    add_row(8'hFF, 1'b1, 1'b0, 1, 1'b1, verdict_of(StLegacy, 20'd1, 1'b0));
    add_row(8'h00, 1'b1, 1'b0, 1, 1'b1, verdict_of(StLegacy, 20'd1, 1'b0));
    // Two bytes with no end mark, closed by an empty mark whose byte and last are ignored.
    add_row(Magic[0], 1'b0, 1'b0, 1, 1'b0, verdict_of(StLegacy, 20'd0, 1'b0));
    add_row(Magic[1], 1'b0, 1'b0, 1, 1'b0, verdict_of(StLegacy, 20'd0, 1'b0));
    add_row(8'h56, 1'b1, 1'b1, 1, 1'b1, verdict_of(StLegacy, 20'd2, 1'b0));
    // Reserved prefix alone, then the full magic with no header: both corrupt.
    for (int i = 0; i < 4; i++) begin
      add_row(Magic[i], i == 3, 1'b0, 1, i == 3, verdict_of(StCorrupt, 20'd0, 1'b0));
    end
    for (int i = 0; i < 8; i++) begin
      add_row(Magic[i], i == 7, 1'b0, 1, i == 7, verdict_of(StCorrupt, 20'd0, 1'b0));
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      for (int unsigned k = 1; k <= row.copies; k++) begin
        final_copy = (k == row.copies);
        send_item(row.data_byte, row.last && final_copy, row.empty_mark,
                  row.verdict_given && final_copy, row.verdict, row.copies > 1);
      end
    end
    byte_ch.valid <= 1'b0;
    drain_and_settle();

    // Random records under the reset settings, then under each new setting.
    run_random_phase(PhaseItems);
    drain_and_settle();
    for (int s = 0; s < 6; s++) begin
      case (s)
        0: begin
          schema = '0;
          limit = '0;
        end
        1: begin
          schema = '1;
          limit = '1;
        end
        2: begin
          schema = $urandom();
          limit = 17'd65536;
        end
        3: begin
          schema = $urandom();
          limit = $urandom_range(1, 40);
        end
        4: begin
          schema = 32'd1;
          limit = 17'd1;
        end
        default: begin
          schema = $urandom();
          limit = $urandom_range(41, 65535);
        end
      endcase
      apply_setting(schema, limit);
      if (s == 2) hold_req = 1'b1;
      run_random_phase(PhaseItems);
      drain_and_settle();
    end
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d requests in: directed edge records, then random records %s",
             items_sent, "of every shape");
    $display("under %0d register settings. Verdicts checked: %0d (%0d typed, %0d legacy, %0d %s",
             settings_used, verdicts_checked, typed_seen, legacy_seen, corrupt_seen,
             $sformatf("corrupt), %0d mismatches.", error_count));
    if (error_count == 0 && verdicts_due.size() == 0) begin
      $display("tb_journal_record_validator_unit: clean");
    end else begin
      $display("tb_journal_record_validator_unit: errors");
    end
    $finish;
  end

endmodule
